// ===== rtl/lsls_pkg.sv =====
// ----------------------------------------------------------------------------
// lsls_pkg
// Shared types and constants for the link status LED sequencer: operation
// codes, LED mode codes, register indexes, reset values and item structs.
// ----------------------------------------------------------------------------
package lsls_pkg;

    // Field widths
    localparam int OpW      = 3;
    localparam int HalfW    = 16;
    localparam int HoldW    = 16;
    localparam int RefreshW = 10;
    localparam int IndW     = 8;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Stream widths
    localparam int InDataW  = 16;  // 12 bits of fields, zero filled
    localparam int OutDataW = 8;   // 4 bits of fields, zero filled

    // Bit of the host indicator byte that carries caps lock
    localparam int CapsBit = 1;

    // Register reset values
    localparam logic [HalfW-1:0]    PairingHalfRst    = 16'd120;
    localparam logic [HalfW-1:0]    ConnectingHalfRst = 16'd500;
    localparam logic [HoldW-1:0]    ConnectedHoldRst  = 16'd3000;
    localparam logic [RefreshW-1:0] RefreshPeriodRst  = 10'd50;

    // Item kinds
    typedef enum logic [OpW-1:0] {
        OP_TICK   = 3'd0,
        OP_STATUS = 3'd1,
        OP_CAPS   = 3'd2,
        OP_SLEEP  = 3'd3,
        OP_WAKE   = 3'd4
    } t_op;

    // LED mode codes as reported on the output
    typedef enum logic [1:0] {
        MODE_OFF        = 2'd0,
        MODE_PAIRING    = 2'd1,
        MODE_CONNECTING = 2'd2,
        MODE_CONNECTED  = 2'd3
    } t_led_mode;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_PAIRING_HALF    = 2'd0,
        REG_CONNECTING_HALF = 2'd1,
        REG_CONNECTED_HOLD  = 2'd2,
        REG_REFRESH_PERIOD  = 2'd3
    } t_reg_idx;

    // Configuration as seen by the state update
    typedef struct packed {
        logic [HalfW-1:0]    pairing_half;
        logic [HalfW-1:0]    connecting_half;
        logic [HoldW-1:0]    connected_hold;
        logic [RefreshW-1:0] refresh_period;
    } t_cfg;

    // One input item
    typedef struct packed {
        logic [OpW-1:0] op;
        logic           usb_selected;
        logic           profile_connected;
        logic           profile_open;
        logic           address_known;
        logic [IndW-1:0] indicator_bits;
    } t_item;

    // One result item
    typedef struct packed {
        logic      link_led;
        logic      caps_led;
        logic [1:0] led_mode;
    } t_result;

endpackage

// ===== rtl/lsls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsls_cfg_regs
// Configuration register file: four timing registers written through a
// plain write port, loaded with their default timing at reset.
// ----------------------------------------------------------------------------
module lsls_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsls_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [lsls_pkg::CfgDataW-1:0]     i_cfg_data,
    output lsls_pkg::t_cfg                    o_cfg
);

    lsls_pkg::t_cfg r_cfg;

    // Register writes; refresh period keeps its low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pairing_half    <= lsls_pkg::PairingHalfRst;
            r_cfg.connecting_half <= lsls_pkg::ConnectingHalfRst;
            r_cfg.connected_hold  <= lsls_pkg::ConnectedHoldRst;
            r_cfg.refresh_period  <= lsls_pkg::RefreshPeriodRst;
        end else if (i_cfg_we) begin
            case (lsls_pkg::t_reg_idx'(i_cfg_idx))
                lsls_pkg::REG_PAIRING_HALF: begin
                    r_cfg.pairing_half <= i_cfg_data[lsls_pkg::HalfW-1:0];
                end
                lsls_pkg::REG_CONNECTING_HALF: begin
                    r_cfg.connecting_half <= i_cfg_data[lsls_pkg::HalfW-1:0];
                end
                lsls_pkg::REG_CONNECTED_HOLD: begin
                    r_cfg.connected_hold <= i_cfg_data[lsls_pkg::HoldW-1:0];
                end
                lsls_pkg::REG_REFRESH_PERIOD: begin
                    r_cfg.refresh_period <= i_cfg_data[lsls_pkg::RefreshW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lsls_state_update.sv =====
// ----------------------------------------------------------------------------
// lsls_state_update
// Sequencer state and its one-item update: blink phases, hold timer,
// refresh timer, mode selection and both LEDs. The result carries the
// state after the item.
// ----------------------------------------------------------------------------
module lsls_state_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lsls_pkg::t_item i_item,
    input  lsls_pkg::t_cfg  i_cfg,
    output lsls_pkg::t_result o_result
);

    typedef struct packed {
        logic                 led;
        logic                 ren;
        lsls_pkg::t_led_mode  mode;
    } t_refresh;

    // State
    lsls_pkg::t_led_mode              r_mode;
    logic                             r_ren;
    logic [lsls_pkg::RefreshW-1:0]    r_rcount;
    logic [lsls_pkg::HoldW-1:0]       r_hold;
    logic [lsls_pkg::HalfW-1:0]       r_pcount;
    logic                             r_pphase;
    logic [lsls_pkg::HalfW-1:0]       r_ccount;
    logic                             r_cphase;
    logic                             r_link;
    logic                             r_caps;

    lsls_pkg::t_led_mode              n_mode;
    logic                             n_ren;
    logic [lsls_pkg::RefreshW-1:0]    n_rcount;
    logic [lsls_pkg::HoldW-1:0]       n_hold;
    logic [lsls_pkg::HalfW-1:0]       n_pcount;
    logic                             n_pphase;
    logic [lsls_pkg::HalfW-1:0]       n_ccount;
    logic                             n_cphase;
    logic                             n_link;
    logic                             n_caps;

    // Half-period counter step: returns {phase, count}
    function automatic logic [lsls_pkg::HalfW:0] f_phase(
        input logic [lsls_pkg::HalfW-1:0] cnt,
        input logic                       ph,
        input logic [lsls_pkg::HalfW-1:0] half
    );
        logic [lsls_pkg::HalfW-1:0] nxt;
        nxt = cnt + lsls_pkg::HalfW'(1);
        if (nxt >= half || nxt == '0) begin
            f_phase = {~ph, {lsls_pkg::HalfW{1'b0}}};
        end else begin
            f_phase = {ph, nxt};
        end
    endfunction

    // Link LED refresh from the current mode
    function automatic t_refresh f_refresh(
        input lsls_pkg::t_led_mode        mode,
        input logic                       ren,
        input logic                       pph,
        input logic                       cph,
        input logic [lsls_pkg::HoldW-1:0] hold,
        input logic [lsls_pkg::HoldW-1:0] hold_ms
    );
        t_refresh res;
        res.led  = 1'b0;
        res.ren  = ren;
        res.mode = mode;
        case (mode)
            lsls_pkg::MODE_PAIRING:    res.led = pph;
            lsls_pkg::MODE_CONNECTING: res.led = cph;
            lsls_pkg::MODE_CONNECTED: begin
                if (hold < hold_ms) begin
                    res.led = 1'b1;
                end else begin
                    res.ren  = 1'b0;
                    res.mode = lsls_pkg::MODE_OFF;
                end
            end
            default: res.led = 1'b0;
        endcase
        return res;
    endfunction

    // Mode chosen by a link status, highest priority first
    function automatic lsls_pkg::t_led_mode f_pick(input lsls_pkg::t_item it);
        lsls_pkg::t_led_mode m;
        if (it.usb_selected)           m = lsls_pkg::MODE_OFF;
        else if (it.profile_connected) m = lsls_pkg::MODE_CONNECTED;
        else if (it.profile_open)      m = lsls_pkg::MODE_PAIRING;
        else if (it.address_known)     m = lsls_pkg::MODE_CONNECTING;
        else                           m = lsls_pkg::MODE_PAIRING;
        return m;
    endfunction

    // Next state for the item at hand
    always_comb begin
        logic [lsls_pkg::HalfW:0]      pstep;
        logic [lsls_pkg::HalfW:0]      cstep;
        logic [lsls_pkg::RefreshW:0]   rnext;
        lsls_pkg::t_led_mode           pick;
        t_refresh                      rf;

        n_mode   = r_mode;
        n_ren    = r_ren;
        n_rcount = r_rcount;
        n_hold   = r_hold;
        n_pcount = r_pcount;
        n_pphase = r_pphase;
        n_ccount = r_ccount;
        n_cphase = r_cphase;
        n_link   = r_link;
        n_caps   = r_caps;

        pstep = f_phase(r_pcount, r_pphase, i_cfg.pairing_half);
        cstep = f_phase(r_ccount, r_cphase, i_cfg.connecting_half);
        rnext = {1'b0, r_rcount} + (lsls_pkg::RefreshW+1)'(1);
        pick  = f_pick(i_item);
        rf    = '0;

        case (lsls_pkg::t_op'(i_item.op))
            lsls_pkg::OP_TICK: begin
                n_pphase = pstep[lsls_pkg::HalfW];
                n_pcount = pstep[lsls_pkg::HalfW-1:0];
                n_cphase = cstep[lsls_pkg::HalfW];
                n_ccount = cstep[lsls_pkg::HalfW-1:0];
                if (r_hold != {lsls_pkg::HoldW{1'b1}}) begin
                    n_hold = r_hold + lsls_pkg::HoldW'(1);
                end
                if (r_ren) begin
                    if (rnext >= {1'b0, i_cfg.refresh_period} ||
                        rnext[lsls_pkg::RefreshW]) begin
                        n_rcount = '0;
                        rf = f_refresh(r_mode, r_ren, n_pphase, n_cphase, n_hold,
                                       i_cfg.connected_hold);
                        n_link = rf.led;
                        n_ren  = rf.ren;
                        n_mode = rf.mode;
                    end else begin
                        n_rcount = rnext[lsls_pkg::RefreshW-1:0];
                    end
                end
            end
            lsls_pkg::OP_STATUS, lsls_pkg::OP_WAKE: begin
                // Mode change only when the choice differs
                if (pick != r_mode) begin
                    n_mode = pick;
                    n_hold = '0;
                    if (pick == lsls_pkg::MODE_OFF) begin
                        n_ren  = 1'b0;
                        n_link = 1'b0;
                    end else if (!r_ren) begin
                        n_rcount = '0;
                        rf = f_refresh(pick, 1'b1, r_pphase, r_cphase, '0,
                                       i_cfg.connected_hold);
                        n_link = rf.led;
                        n_ren  = rf.ren;
                        n_mode = rf.mode;
                    end
                end
                if (i_item.op == lsls_pkg::OP_WAKE) begin
                    n_caps = i_item.indicator_bits[lsls_pkg::CapsBit];
                end
            end
            lsls_pkg::OP_CAPS: begin
                n_caps = i_item.indicator_bits[lsls_pkg::CapsBit];
            end
            lsls_pkg::OP_SLEEP: begin
                n_link = 1'b0;
                n_caps = 1'b0;
                n_ren  = 1'b0;
                n_mode = lsls_pkg::MODE_OFF;
            end
            default: begin
            end
        endcase
    end

    // State registers, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= lsls_pkg::MODE_OFF;
            r_ren    <= 1'b0;
            r_rcount <= '0;
            r_hold   <= '0;
            r_pcount <= '0;
            r_pphase <= 1'b0;
            r_ccount <= '0;
            r_cphase <= 1'b0;
            r_link   <= 1'b0;
            r_caps   <= 1'b0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_ren    <= n_ren;
            r_rcount <= n_rcount;
            r_hold   <= n_hold;
            r_pcount <= n_pcount;
            r_pphase <= n_pphase;
            r_ccount <= n_ccount;
            r_cphase <= n_cphase;
            r_link   <= n_link;
            r_caps   <= n_caps;
        end
    end

    // Result reports the state after this item
    assign o_result.link_led = n_link;
    assign o_result.caps_led = n_caps;
    assign o_result.led_mode = n_mode;

endmodule

// ===== rtl/link_status_led_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// link_status_led_sequencer_core
// Link and caps LED sequencer driven by events and millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: s_axis_tuser carries the item kind (tick, link status,
//    indicators, sleep, wake); s_axis_tdata carries the link status bits and
//    the host indicator byte. Each accepted item gives exactly one result.
//  - Output stream: m_axis_tdata carries link LED, caps LED and LED mode as
//    they stand after that item.
//  - Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write the blink half
//    periods, connected hold time and refresh period; write only when idle.
//  - Path: an accepted item passes the input register, then the state update
//    into the result register.
//  - Throughput: one item per cycle while results are taken; the state update is
//    a single pass of logic between the input register and the result register.
//  - Reset (synchronous, active low): registers take their default timing,
//    mode off, both LEDs off, all timers cleared, both stages empty.
//  - Stall: while a result waits, one more item sits in the input register;
//    then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module link_status_led_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] usb_selected, [1] profile_connected, [2] profile_open,
    // [3] address_known, [11:4] indicator_bits, [15:12] zero
    input  logic [lsls_pkg::InDataW-1:0]      s_axis_tdata,
    // [2:0] op
    input  logic [lsls_pkg::OpW-1:0]          s_axis_tuser,
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] link_led, [1] caps_led, [3:2] led_mode, [7:4] zero
    output logic [lsls_pkg::OutDataW-1:0]     m_axis_tdata,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [lsls_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [lsls_pkg::CfgDataW-1:0]     i_cfg_data
);

    lsls_pkg::t_cfg    cfg;
    lsls_pkg::t_result result;

    logic              r_in_valid;
    lsls_pkg::t_item   r_in_item;
    logic              r_out_valid;
    lsls_pkg::t_result r_out;
    logic              advance;

    // Item moves on when the result register is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.op                <= s_axis_tuser;
            r_in_item.usb_selected      <= s_axis_tdata[0];
            r_in_item.profile_connected <= s_axis_tdata[1];
            r_in_item.profile_open      <= s_axis_tdata[2];
            r_in_item.address_known     <= s_axis_tdata[3];
            r_in_item.indicator_bits    <= s_axis_tdata[11:4];
        end
    end

    lsls_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lsls_state_update u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.led_mode, r_out.caps_led, r_out.link_led};

endmodule

// ===== rtl/lsls_checker.sv =====
// ----------------------------------------------------------------------------
// lsls_checker
// Port-level checks on the LED sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lsls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lsls_pkg::OutDataW-1:0]     m_axis_tdata
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With no result pending the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    // Filler bits of a result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
        else $error("result filler bits set");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind link_status_led_sequencer_core lsls_checker u_lsls_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for link_status_led_sequencer_core. A behavioral copy of
// the mode, blink, hold and refresh logic predicts the LED state after every
// accepted item. Each result is checked field by field against the oldest
// prediction. Stimulus covers directed events, random event and tick streams
// under several timing settings, and long output stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Op codes past wake carry no meaning; the block reports its state
    localparam int OpUnusedFirst = 5;
    localparam int OpUnusedLast  = 7;
    localparam int RxHoldCycles  = 80;
    localparam int BurstItems    = 24;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [lsls_pkg::InDataW-1:0]  s_axis_tdata = '0;
    logic [lsls_pkg::OpW-1:0]      s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [lsls_pkg::OutDataW-1:0] m_axis_tdata;
    logic                          i_cfg_we = 1'b0;
    logic [lsls_pkg::CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [lsls_pkg::CfgDataW-1:0] i_cfg_data = '0;

    link_status_led_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predicted LED states, oldest first
    lsls_pkg::t_result led_state_q[$];
    int      error_count = 0;
    bit      no_idle = 1'b0;
    int      rx_hold = 0;

    // Timing copy
    logic [lsls_pkg::HalfW-1:0]    pair_half;
    logic [lsls_pkg::HalfW-1:0]    conn_half;
    logic [lsls_pkg::HoldW-1:0]    hold_limit;
    logic [lsls_pkg::RefreshW-1:0] refresh_period;

    // Sequencer state copy
    lsls_pkg::t_led_mode           cur_mode;
    bit                            refresh_on;
    logic [lsls_pkg::RefreshW-1:0] refresh_cnt;
    logic [lsls_pkg::HoldW-1:0]    hold_ms;
    logic [lsls_pkg::HalfW-1:0]    pair_cnt;
    bit                            pair_phase;
    logic [lsls_pkg::HalfW-1:0]    conn_cnt;
    bit                            conn_phase;
    bit                            link_on;
    bit                            caps_on;

    function automatic void clear_model();
        pair_half      = lsls_pkg::PairingHalfRst;
        conn_half      = lsls_pkg::ConnectingHalfRst;
        hold_limit     = lsls_pkg::ConnectedHoldRst;
        refresh_period = lsls_pkg::RefreshPeriodRst;
        cur_mode       = lsls_pkg::MODE_OFF;
        refresh_on     = 1'b0;
        refresh_cnt    = '0;
        hold_ms        = '0;
        pair_cnt       = '0;
        pair_phase     = 1'b0;
        conn_cnt       = '0;
        conn_phase     = 1'b0;
        link_on        = 1'b0;
        caps_on        = 1'b0;
    endfunction

    // Re-evaluate link LED; connected mode drops to off once the hold runs out
    function automatic void refresh_link_led();
        case (cur_mode)
            lsls_pkg::MODE_PAIRING:    link_on = pair_phase;
            lsls_pkg::MODE_CONNECTING: link_on = conn_phase;
            lsls_pkg::MODE_CONNECTED: begin
                if (hold_ms < hold_limit) begin
                    link_on = 1'b1;
                end else begin
                    link_on    = 1'b0;
                    refresh_on = 1'b0;
                    cur_mode   = lsls_pkg::MODE_OFF;
                end
            end
            default:         link_on = 1'b0;
        endcase
    endfunction

    // Half-period counter; a zero half period toggles every tick
    function automatic void step_blink(inout logic [lsls_pkg::HalfW-1:0] cnt, inout bit ph,
                                       input logic [lsls_pkg::HalfW-1:0] half);
        logic [lsls_pkg::HalfW-1:0] nxt;
        nxt = cnt + lsls_pkg::HalfW'(1);
        if (nxt >= half || nxt == '0) begin
            cnt = '0;
            ph  = ~ph;
        end else begin
            cnt = nxt;
        end
    endfunction

    function automatic void change_mode(lsls_pkg::t_led_mode m);
        if (m == cur_mode)
            return;
        cur_mode = m;
        hold_ms  = '0;
        if (m == lsls_pkg::MODE_OFF) begin
            refresh_on = 1'b0;
            link_on    = 1'b0;
            return;
        end
        if (!refresh_on) begin
            refresh_on  = 1'b1;
            refresh_cnt = '0;
            refresh_link_led();
        end
    endfunction

    // Mode priority: USB, connected, open, known address, else pairing
    function automatic void apply_link_status(lsls_pkg::t_item it);
        if (it.usb_selected)
            change_mode(lsls_pkg::MODE_OFF);
        else if (it.profile_connected)
            change_mode(lsls_pkg::MODE_CONNECTED);
        else if (it.profile_open)
            change_mode(lsls_pkg::MODE_PAIRING);
        else if (it.address_known)
            change_mode(lsls_pkg::MODE_CONNECTING);
        else
            change_mode(lsls_pkg::MODE_PAIRING);
    endfunction

    function automatic void ms_tick();
        int nxt;
        step_blink(pair_cnt, pair_phase, pair_half);
        step_blink(conn_cnt, conn_phase, conn_half);
        if (hold_ms != '1)
            hold_ms = hold_ms + lsls_pkg::HoldW'(1);
        if (refresh_on) begin
            nxt = int'(refresh_cnt) + 1;
            if (nxt >= int'(refresh_period) || nxt > 1023) begin
                refresh_cnt = '0;
                refresh_link_led();
            end else begin
                refresh_cnt = lsls_pkg::RefreshW'(nxt);
            end
        end
    endfunction

    // LED state after one item
    function automatic lsls_pkg::t_result predict_leds(lsls_pkg::t_item it);
        lsls_pkg::t_result r;
        case (it.op)
            lsls_pkg::OP_TICK:   ms_tick();
            lsls_pkg::OP_STATUS: apply_link_status(it);
            lsls_pkg::OP_CAPS:   caps_on = it.indicator_bits[lsls_pkg::CapsBit];
            lsls_pkg::OP_SLEEP: begin
                link_on    = 1'b0;
                caps_on    = 1'b0;
                refresh_on = 1'b0;
                cur_mode   = lsls_pkg::MODE_OFF;
            end
            lsls_pkg::OP_WAKE: begin
                apply_link_status(it);
                caps_on = it.indicator_bits[lsls_pkg::CapsBit];
            end
            default: ;
        endcase
        r.link_led = link_on;
        r.caps_led = caps_on;
        r.led_mode = cur_mode;
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(25, 8);
    endfunction

    function automatic lsls_pkg::t_item make_item(logic [lsls_pkg::OpW-1:0] op, bit usb,
                                                  bit conn, bit open_prof, bit addr,
                                                  logic [lsls_pkg::IndW-1:0] ind);
        lsls_pkg::t_item it;
        it.op                = op;
        it.usb_selected      = usb;
        it.profile_connected = conn;
        it.profile_open      = open_prof;
        it.address_known     = addr;
        it.indicator_bits    = ind;
        return it;
    endfunction

    function automatic lsls_pkg::t_item rand_item();
        int r;
        logic [lsls_pkg::OpW-1:0] op;
        r = $urandom_range(99);
        if (r < 50)
            op = lsls_pkg::OP_TICK;
        else if (r < 68)
            op = lsls_pkg::OP_STATUS;
        else if (r < 76)
            op = lsls_pkg::OP_CAPS;
        else if (r < 81)
            op = lsls_pkg::OP_SLEEP;
        else if (r < 93)
            op = lsls_pkg::OP_WAKE;
        else
            op = lsls_pkg::OpW'($urandom_range(OpUnusedLast, OpUnusedFirst));
        return make_item(op, $urandom_range(99) < 15, $urandom_range(99) < 25,
                         $urandom_range(99) < 35, $urandom_range(99) < 50,
                         lsls_pkg::IndW'($urandom_range(255)));
    endfunction

    // Offer one item; tvalid stays up when the next one follows at once
    task automatic send_item(lsls_pkg::t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {4'b0, it.indicator_bits, it.address_known, it.profile_open,
                          it.profile_connected, it.usb_selected};
        do @(posedge i_clk); while (!s_axis_tready);
        led_state_q.push_back(predict_leds(it));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (led_state_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(lsls_pkg::t_reg_idx idx, logic [lsls_pkg::CfgDataW-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            lsls_pkg::REG_PAIRING_HALF:    pair_half      = v;
            lsls_pkg::REG_CONNECTING_HALF: conn_half      = v;
            lsls_pkg::REG_CONNECTED_HOLD:  hold_limit     = v;
            lsls_pkg::REG_REFRESH_PERIOD:  refresh_period = v[lsls_pkg::RefreshW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [lsls_pkg::HalfW-1:0] p, logic [lsls_pkg::HalfW-1:0] c,
                             logic [lsls_pkg::HoldW-1:0] h,
                             logic [lsls_pkg::RefreshW-1:0] r);
        wait_drained();
        cfg_write(lsls_pkg::REG_PAIRING_HALF, p);
        cfg_write(lsls_pkg::REG_CONNECTING_HALF, c);
        cfg_write(lsls_pkg::REG_CONNECTED_HOLD, h);
        cfg_write(lsls_pkg::REG_REFRESH_PERIOD, lsls_pkg::CfgDataW'(r));
    endtask

    // Random events; a status or wake is usually followed by a run of ticks
    task automatic run_random(int n);
        int sent;
        int run;
        lsls_pkg::t_item it;
        sent = 0;
        while (sent < n) begin
            it = rand_item();
            send_item(it);
            sent++;
            if (it.op == lsls_pkg::OP_STATUS || it.op == lsls_pkg::OP_WAKE) begin
                run = $urandom_range(30, 0);
                repeat (run) begin
                    it    = rand_item();
                    it.op = lsls_pkg::OP_TICK;
                    send_item(it);
                end
                sent += run;
            end
        end
    endtask

    // Every priority level, caps bit, sleep, events while asleep, wake, unused ops
    task automatic test_events_at_reset();
        send_item(make_item(lsls_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00));
        send_item(make_item(lsls_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFD));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b0, 1'b0, 1'b0, 1'b0, 8'h02));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b0, 1'b0, 1'b0, 1'b0, 8'h02));
        send_item(make_item(lsls_pkg::OP_SLEEP, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        // asleep: events still apply
        send_item(make_item(lsls_pkg::OP_STATUS, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
        send_item(make_item(lsls_pkg::OP_CAPS, 1'b0, 1'b0, 1'b0, 1'b0, 8'h02));
        send_item(make_item(lsls_pkg::OP_SLEEP, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_WAKE, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF));
        for (int op = OpUnusedFirst; op <= OpUnusedLast; op++)
            send_item(make_item(lsls_pkg::OpW'(op), 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_item(make_item(lsls_pkg::OP_WAKE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_item(make_item(lsls_pkg::OP_WAKE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h02));
        wait_drained();
    endtask

    // Short periods so blinking, hold expiry and refresh all show up
    task automatic test_blink_and_hold(int n);
        configure(lsls_pkg::HalfW'($urandom_range(6, 1)),
                  lsls_pkg::HalfW'($urandom_range(10, 1)),
                  lsls_pkg::HoldW'($urandom_range(80, 5)),
                  lsls_pkg::RefreshW'($urandom_range(8, 1)));
        run_random(n);
    endtask

    task automatic test_extreme_settings();
        // minimums, back to back on both sides
        configure(16'd1, 16'd1, 16'd1, 10'd1);
        no_idle = 1'b1;
        run_random(200);
        no_idle = 1'b0;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1000);
        run_random(200);
        // zero periods behave as one
        configure(16'd0, 16'd0, 16'd0, 10'd0);
        run_random(150);
    endtask

    // Output held off while items keep coming, then the sender waits it out
    task automatic test_backpressure();
        configure(16'd3, 16'd5, 16'd20, 10'd2);
        repeat (2) begin
            rx_hold = RxHoldCycles;
            no_idle = 1'b1;
            run_random(BurstItems);
            no_idle = 1'b0;
            wait_drained();
        end
    endtask

    // Result side: random stalls, or a long hold-off when requested
    initial begin
        int gap;
        int n;
        wait (i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        lsls_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (led_state_q.size() == 0) begin
                $error("result with no item pending: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = led_state_q.pop_front();
                if (m_axis_tdata[0] !== want.link_led) begin
                    $error("link_led: expected %0d, got %0d", want.link_led, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[1] !== want.caps_led) begin
                    $error("caps_led: expected %0d, got %0d", want.caps_led, m_axis_tdata[1]);
                    error_count++;
                end
                if (m_axis_tdata[3:2] !== want.led_mode) begin
                    $error("led_mode: expected %0d, got %0d", want.led_mode,
                           m_axis_tdata[3:2]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_events_at_reset();
        test_blink_and_hold(400);
        test_extreme_settings();
        test_backpressure();
        test_blink_and_hold(400);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && led_state_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lsls_pkg.sv
rtl/lsls_cfg_regs.sv
rtl/lsls_state_update.sv
rtl/link_status_led_sequencer_core.sv
rtl/lsls_checker.sv
tb/sv/tb.sv
